// ----- rtl/ojm_pkg.sv -----
// Shared types, register codes and widths for the omni-drive joystick mixer.
package ojm_pkg;

	localparam int DUTY_FRAC_BITS_DEF = 15;
	localparam int PERMILLE_W = 10;
	localparam int MAG_W = 10;
	localparam int SHIFT_W = 11;
	localparam int SQ_W = 21;
	localparam int DUTY_W = 16;
	localparam int DB_W = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 10;

	localparam logic [MAG_W-1:0] MID_POINT_RST = 10'd83;
	localparam logic [DB_W-1:0] DEADBAND_RST = 8'd3;
	localparam logic [DB_W-1:0] DIAG_TOL_RST = 8'd10;
	localparam logic [MAG_W-1:0] AMPLITUDE_RST = 10'd28;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MID_POINT,
		CFG_DEADBAND,
		CFG_DIAG_TOL,
		CFG_AMPLITUDE
	} cfg_idx_t;

	typedef enum logic [2:0] {
		MODE_STOP,
		MODE_NS,
		MODE_EW,
		MODE_NWSE,
		MODE_NESW,
		MODE_CCW,
		MODE_CW
	} mode_t;

	typedef struct packed {
		mode_t mode;
		logic  neg_x;
		logic  neg_y;
		logic  neg_r;
	} meta_t;

	typedef struct packed {
		logic [PERMILLE_W-1:0] left_x_permille;
		logic [PERMILLE_W-1:0] left_y_permille;
		logic [PERMILLE_W-1:0] right_x_permille;
	} in_t;

	typedef struct packed {
		mode_t             drive_mode;
		logic [DUTY_W-1:0] motor_a_duty;
		logic              motor_a_forward;
		logic [DUTY_W-1:0] motor_b_duty;
		logic              motor_b_forward;
		logic [DUTY_W-1:0] motor_c_duty;
		logic              motor_c_forward;
		logic [DUTY_W-1:0] motor_d_duty;
		logic              motor_d_forward;
	} out_t;

endpackage

// ----- rtl/ojm_front.sv -----
// Front stages: centre and deadband the readings, classify the mode, form the operands.
module ojm_front #(
	parameter int DUTY_FRAC_BITS = ojm_pkg::DUTY_FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                vld_in,
	input  ojm_pkg::in_t                        data_in,
	input  logic [ojm_pkg::MAG_W-1:0]           mid_point,
	input  logic [ojm_pkg::DB_W-1:0]            deadband,
	input  logic [ojm_pkg::DB_W-1:0]            diag_tolerance,
	output logic                                vld_out,
	output logic [2*(DUTY_FRAC_BITS+10)-1:0]    rad_out,
	output logic [DUTY_FRAC_BITS+10-1:0]        lin_out,
	output ojm_pkg::meta_t                      meta_out
);
	import ojm_pkg::*;

	localparam int NW = DUTY_FRAC_BITS + 10;
	localparam int RAD_W = 2 * NW;

	function automatic logic signed [SHIFT_W-1:0] shift_reading(
		input logic [PERMILLE_W-1:0] raw,
		input logic [MAG_W-1:0]      mid,
		input logic [DB_W-1:0]       db
	);
		logic signed [SHIFT_W-1:0] d;
		logic [SHIFT_W-1:0]        m;
		d = $signed({1'b0, raw}) - $signed({1'b0, mid});
		m = d < 0 ? SHIFT_W'(-d) : SHIFT_W'(d);
		return (m < {3'b000, db}) ? '0 : d;
	endfunction

	logic                      v_s1, v_s2, v_s3;
	logic signed [SHIFT_W-1:0] x_s1, y_s1, r_s1;
	meta_t                     meta_s2, meta_s3;
	logic [MAG_W-1:0]          ax_s2, ay_s2, mag_s2;
	logic [RAD_W-1:0]          rad_s3;
	logic [NW-1:0]             lin_s3;

	logic [MAG_W-1:0]   ax, ay, ar, diff, lin_mag;
	logic               is_ns, is_ew, is_diag, sx, sy, sr;
	meta_t              meta_c;
	logic [2*MAG_W-1:0] sqx, sqy;
	logic [SQ_W-1:0]    sq_sum;

	always_comb begin
		ax = MAG_W'(x_s1 < 0 ? -x_s1 : x_s1);
		ay = MAG_W'(y_s1 < 0 ? -y_s1 : y_s1);
		ar = MAG_W'(r_s1 < 0 ? -r_s1 : r_s1);
		sx = x_s1[SHIFT_W-1];
		sy = y_s1[SHIFT_W-1];
		sr = r_s1[SHIFT_W-1];
		diff = ax > ay ? ax - ay : ay - ax;
		is_ns = {1'b0, ay} > {ax, 1'b0};
		is_ew = {1'b0, ax} > {ay, 1'b0};
		is_diag = (diff < {2'b00, diag_tolerance}) && (x_s1 != '0) && (y_s1 != '0);
		if (is_ns) begin
			meta_c.mode = MODE_NS;
			lin_mag = ay;
		end else if (is_ew) begin
			meta_c.mode = MODE_EW;
			lin_mag = ax;
		end else if (is_diag && (sx != sy)) begin
			meta_c.mode = MODE_NWSE;
			lin_mag = ar;
		end else if (is_diag) begin
			meta_c.mode = MODE_NESW;
			lin_mag = ar;
		end else if (r_s1 != '0) begin
			meta_c.mode = sr ? MODE_CCW : MODE_CW;
			lin_mag = ar;
		end else begin
			meta_c.mode = MODE_STOP;
			lin_mag = ar;
		end
		meta_c.neg_x = sx;
		meta_c.neg_y = sy;
		meta_c.neg_r = sr;
	end

	assign sqx = ax_s2 * ax_s2;
	assign sqy = ay_s2 * ay_s2;
	assign sq_sum = {1'b0, sqx} + {1'b0, sqy};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= vld_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= shift_reading(data_in.left_x_permille, mid_point, deadband);
			y_s1 <= shift_reading(data_in.left_y_permille, mid_point, deadband);
			r_s1 <= shift_reading(data_in.right_x_permille, mid_point, deadband);
			meta_s2 <= meta_c;
			ax_s2 <= ax;
			ay_s2 <= ay;
			mag_s2 <= lin_mag;
			meta_s3 <= meta_s2;
			rad_s3 <= RAD_W'(sq_sum) << (2 * DUTY_FRAC_BITS - 1);
			lin_s3 <= NW'(mag_s2) << DUTY_FRAC_BITS;
		end
	end

	assign vld_out = v_s3;
	assign rad_out = rad_s3;
	assign lin_out = lin_s3;
	assign meta_out = meta_s3;

endmodule

// ----- rtl/ojm_sqrt.sv -----
// Pipelined restoring square root, one root bit per stage, with side data alongside.
module ojm_sqrt #(
	parameter int DUTY_FRAC_BITS = ojm_pkg::DUTY_FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              vld_in,
	input  logic [2*(DUTY_FRAC_BITS+10)-1:0]  rad_in,
	input  logic [DUTY_FRAC_BITS+10-1:0]      lin_in,
	input  ojm_pkg::meta_t                    meta_in,
	output logic                              vld_out,
	output logic [DUTY_FRAC_BITS+10-1:0]      root_out,
	output logic [DUTY_FRAC_BITS+10-1:0]      lin_out,
	output ojm_pkg::meta_t                    meta_out
);
	import ojm_pkg::*;

	localparam int NW = DUTY_FRAC_BITS + 10;
	localparam int RAD_W = 2 * NW;
	localparam int REM_W = NW + 1;

	logic             v_s    [NW+1];
	logic [RAD_W-1:0] rad_s  [NW+1];
	logic [REM_W-1:0] rem_s  [NW+1];
	logic [NW-1:0]    root_s [NW+1];
	logic [NW-1:0]    lin_s  [NW+1];
	meta_t            meta_s [NW+1];

	assign v_s[0] = vld_in;
	assign rad_s[0] = rad_in;
	assign rem_s[0] = '0;
	assign root_s[0] = '0;
	assign lin_s[0] = lin_in;
	assign meta_s[0] = meta_in;

	for (genvar g = 0; g < NW; g++) begin : g_stage
		logic [REM_W+1:0] rem_sh, trial, rem_nx;
		logic             ge;

		always_comb begin
			rem_sh = {rem_s[g], rad_s[g][RAD_W-1 -: 2]};
			trial = {1'b0, root_s[g], 2'b01};
			ge = rem_sh >= trial;
			rem_nx = ge ? rem_sh - trial : rem_sh;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g+1] <= 1'b0;
			end else if (en) begin
				v_s[g+1] <= v_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[g+1] <= rad_s[g] << 2;
				rem_s[g+1] <= REM_W'(rem_nx);
				root_s[g+1] <= {root_s[g][NW-2:0], ge};
				lin_s[g+1] <= lin_s[g];
				meta_s[g+1] <= meta_s[g];
			end
		end
	end

	assign vld_out = v_s[NW];
	assign root_out = root_s[NW];
	assign lin_out = lin_s[NW];
	assign meta_out = meta_s[NW];

endmodule

// ----- rtl/ojm_div.sv -----
// Pipelined restoring divider by the amplitude, one quotient bit per stage.
module ojm_div #(
	parameter int DUTY_FRAC_BITS = ojm_pkg::DUTY_FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic [ojm_pkg::MAG_W-1:0]     divisor,
	input  logic                          vld_in,
	input  logic [DUTY_FRAC_BITS+10-1:0]  num_in,
	input  ojm_pkg::meta_t                meta_in,
	output logic                          vld_out,
	output logic [DUTY_FRAC_BITS+10-1:0]  quot_out,
	output ojm_pkg::meta_t                meta_out
);
	import ojm_pkg::*;

	localparam int NW = DUTY_FRAC_BITS + 10;

	logic             v_s    [NW+1];
	logic [NW-1:0]    nq_s   [NW+1];
	logic [MAG_W-1:0] rem_s  [NW+1];
	meta_t            meta_s [NW+1];

	assign v_s[0] = vld_in;
	assign nq_s[0] = num_in;
	assign rem_s[0] = '0;
	assign meta_s[0] = meta_in;

	// numerator bits shift out at the top while quotient bits shift in below
	for (genvar g = 0; g < NW; g++) begin : g_stage
		logic [MAG_W:0] rem_sh, rem_nx;
		logic           ge;

		always_comb begin
			rem_sh = {rem_s[g], nq_s[g][NW-1]};
			ge = rem_sh >= {1'b0, divisor};
			rem_nx = ge ? rem_sh - {1'b0, divisor} : rem_sh;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g+1] <= 1'b0;
			end else if (en) begin
				v_s[g+1] <= v_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				nq_s[g+1] <= {nq_s[g][NW-2:0], ge};
				rem_s[g+1] <= MAG_W'(rem_nx);
				meta_s[g+1] <= meta_s[g];
			end
		end
	end

	assign vld_out = v_s[NW];
	assign quot_out = nq_s[NW];
	assign meta_out = meta_s[NW];

endmodule

// ----- rtl/omni_drive_joystick_mixer.sv -----
// Omni-drive joystick mixer: three stick readings in, drive mode and four motor duties out.
//
// Input beats on in_valid/in_ready carry left x, left y and right x in permille.
// Each beat yields exactly one output beat on out_valid/out_ready with the drive
// mode and a duty plus direction for each of motors A to D.
// Registers are written over cfg_valid/cfg_ready (always ready) by index: 0 mid
// point, 1 deadband, 2 diagonal tolerance, 3 amplitude; write them only while idle.
// The datapath is a single pipeline: three front stages, a square root of
// DUTY_FRAC_BITS+10 stages, a divider of DUTY_FRAC_BITS+10 stages and the output
// register. Throughput is one beat per cycle while the receiver takes the output;
// every item passes the same root and divider stages, whichever mode it selects.
// When the receiver holds off a waiting output beat the whole pipeline freezes
// and in_ready drops; nothing is lost or repeated, and flow resumes with out_ready.
// Reset clears all valid bits and loads the register defaults (83, 3, 10, 28).
module omni_drive_joystick_mixer #(
	parameter int DUTY_FRAC_BITS = ojm_pkg::DUTY_FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  ojm_pkg::in_t                   in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output ojm_pkg::out_t                  out_data,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ojm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ojm_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ojm_pkg::*;

	localparam int NW = DUTY_FRAC_BITS + 10;
	localparam logic [NW-1:0] DUTY_ONE = NW'(1) << DUTY_FRAC_BITS;

	logic [MAG_W-1:0] mid_point_q, amplitude_q, amp_eff;
	logic [DB_W-1:0]  deadband_q, diag_tol_q;
	logic             en;

	logic                 fr_vld, sq_vld, dv_vld;
	logic [2*NW-1:0]      fr_rad;
	logic [NW-1:0]        fr_lin, sq_root, sq_lin, dv_num, dv_quot, sat;
	meta_t                fr_meta, sq_meta, dv_meta;
	logic [DUTY_W-1:0]    duty;
	out_t                 res;
	logic                 out_valid_q;
	out_t                 out_data_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_point_q <= MID_POINT_RST;
			deadband_q <= DEADBAND_RST;
			diag_tol_q <= DIAG_TOL_RST;
			amplitude_q <= AMPLITUDE_RST;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_MID_POINT: mid_point_q <= cfg_data;
				CFG_DEADBAND:  deadband_q <= cfg_data[DB_W-1:0];
				CFG_DIAG_TOL:  diag_tol_q <= cfg_data[DB_W-1:0];
				CFG_AMPLITUDE: amplitude_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign amp_eff = (amplitude_q == '0) ? MAG_W'(1) : amplitude_q;

	// advance everything unless a finished beat is held at the output
	assign en = !out_valid_q || out_ready;
	assign in_ready = en;

	ojm_front #(.DUTY_FRAC_BITS(DUTY_FRAC_BITS)) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (en),
		.vld_in         (in_valid),
		.data_in        (in_data),
		.mid_point      (mid_point_q),
		.deadband       (deadband_q),
		.diag_tolerance (diag_tol_q),
		.vld_out        (fr_vld),
		.rad_out        (fr_rad),
		.lin_out        (fr_lin),
		.meta_out       (fr_meta)
	);

	ojm_sqrt #(.DUTY_FRAC_BITS(DUTY_FRAC_BITS)) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vld_in   (fr_vld),
		.rad_in   (fr_rad),
		.lin_in   (fr_lin),
		.meta_in  (fr_meta),
		.vld_out  (sq_vld),
		.root_out (sq_root),
		.lin_out  (sq_lin),
		.meta_out (sq_meta)
	);

	assign dv_num = (sq_meta.mode == MODE_NWSE || sq_meta.mode == MODE_NESW) ? sq_root : sq_lin;

	ojm_div #(.DUTY_FRAC_BITS(DUTY_FRAC_BITS)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.divisor  (amp_eff),
		.vld_in   (sq_vld),
		.num_in   (dv_num),
		.meta_in  (sq_meta),
		.vld_out  (dv_vld),
		.quot_out (dv_quot),
		.meta_out (dv_meta)
	);

	assign sat = (dv_quot > DUTY_ONE) ? DUTY_ONE : dv_quot;
	assign duty = DUTY_W'(sat);

	always_comb begin
		res.drive_mode = dv_meta.mode;
		res.motor_a_duty = duty;
		res.motor_b_duty = duty;
		res.motor_c_duty = duty;
		res.motor_d_duty = duty;
		res.motor_a_forward = 1'b1;
		res.motor_b_forward = 1'b1;
		res.motor_c_forward = 1'b1;
		res.motor_d_forward = 1'b1;
		case (dv_meta.mode)
			MODE_NS: begin
				res.motor_a_forward = dv_meta.neg_y;
				res.motor_b_forward = dv_meta.neg_y;
				res.motor_c_forward = !dv_meta.neg_y;
				res.motor_d_forward = !dv_meta.neg_y;
			end
			MODE_EW: begin
				res.motor_a_forward = !dv_meta.neg_x;
				res.motor_b_forward = dv_meta.neg_x;
				res.motor_c_forward = dv_meta.neg_x;
				res.motor_d_forward = !dv_meta.neg_x;
			end
			MODE_NWSE: begin
				res.motor_a_forward = !dv_meta.neg_x;
				res.motor_c_forward = dv_meta.neg_x;
				res.motor_b_duty = '0;
				res.motor_d_duty = '0;
			end
			MODE_NESW: begin
				res.motor_b_forward = dv_meta.neg_x;
				res.motor_d_forward = !dv_meta.neg_x;
				res.motor_a_duty = '0;
				res.motor_c_duty = '0;
			end
			MODE_CCW, MODE_CW: begin
				res.motor_a_forward = !dv_meta.neg_r;
				res.motor_b_forward = !dv_meta.neg_r;
				res.motor_c_forward = !dv_meta.neg_r;
				res.motor_d_forward = !dv_meta.neg_r;
			end
			default: begin
				res.motor_a_duty = '0;
				res.motor_b_duty = '0;
				res.motor_c_duty = '0;
				res.motor_d_duty = '0;
				res.motor_a_forward = 1'b0;
				res.motor_b_forward = 1'b0;
				res.motor_c_forward = 1'b0;
				res.motor_d_forward = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	a_stop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.drive_mode == MODE_STOP |->
		out_data.motor_a_duty == '0 && out_data.motor_d_duty == '0 &&
		!out_data.motor_a_forward && !out_data.motor_c_forward)
		else $error("stop beat drives a motor");

	a_nwse_idle_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.drive_mode == MODE_NWSE |->
		out_data.motor_b_duty == '0 && out_data.motor_d_duty == '0 &&
		out_data.motor_b_forward && out_data.motor_d_forward)
		else $error("nw-se beat drives motor B or D");

	a_ns_opposed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.drive_mode == MODE_NS |->
		out_data.motor_a_duty == out_data.motor_c_duty &&
		out_data.motor_a_forward != out_data.motor_c_forward)
		else $error("north-south beat with unmatched motor pair");

	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(dv_quot) && $stable(dv_vld) && !$past(in_ready))
		else $error("pipeline moved while output held");

endmodule

// ----- tb/sv/omni_drive_joystick_mixer_checker.sv -----
// Checker for the omni-drive joystick mixer: mirrors registers, predicts each result and compares.
`timescale 1ns / 1ps
module omni_drive_joystick_mixer_checker
	import ojm_pkg::*;
#(
	parameter int DUTY_FRAC_BITS = DUTY_FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  in_t                   in_data,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  out_t                  out_data,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    pending_count
);

	logic [MAG_W-1:0] mid_q;
	logic [DB_W-1:0]  band_q;
	logic [DB_W-1:0]  tol_q;
	logic [MAG_W-1:0] amp_q;
	out_t             drive_q[$];

	assign pending_count = drive_q.size();

	function automatic int centred(logic [PERMILLE_W-1:0] raw);
		int v;
		v = int'(raw) - int'(mid_q);
		return ((v < 0 ? -v : v) < int'(band_q)) ? 0 : v;
	endfunction

	function automatic longint unsigned clip_one(longint unsigned q);
		longint unsigned one;
		one = 64'd1 << DUTY_FRAC_BITS;
		return q > one ? one : q;
	endfunction

	function automatic longint unsigned amp_eff();
		return amp_q == 0 ? 1 : amp_q;
	endfunction

	// integer root of S << (2F-1), bit by bit over a wide radicand, then divided by the amplitude and clipped to one
	function automatic longint unsigned diag_rate(int ax, int ay);
		logic [127:0] wide;
		logic [127:0] rem, root, trial;
		wide = 128'(ax * ax + ay * ay) << (2 * DUTY_FRAC_BITS - 1);
		rem = '0;
		root = '0;
		for (int i = 35; i >= 0; i--) begin
			rem = (rem << 2) | ((wide >> (2 * i)) & 128'd3);
			trial = (root << 2) | 128'd1;
			if (rem >= trial) begin
				rem = rem - trial;
				root = (root << 1) | 128'd1;
			end else begin
				root = root << 1;
			end
		end
		return clip_one(64'(root) / amp_eff());
	endfunction

	function automatic out_t mix_sticks(in_t s);
		out_t o;
		int x, y, r, ax, ay, ar, gap;
		logic diag, sx, sy, sr;
		logic [DUTY_W-1:0] d;
		x = centred(s.left_x_permille);
		y = centred(s.left_y_permille);
		r = centred(s.right_x_permille);
		ax = x < 0 ? -x : x;
		ay = y < 0 ? -y : y;
		ar = r < 0 ? -r : r;
		gap = ax > ay ? ax - ay : ay - ax;
		diag = gap < int'(tol_q) && x != 0 && y != 0;
		sx = x < 0;
		sy = y < 0;
		sr = r < 0;
		o = '0;
		o.motor_a_forward = 1'b1;
		o.motor_b_forward = 1'b1;
		o.motor_c_forward = 1'b1;
		o.motor_d_forward = 1'b1;
		if (ay > 2 * ax) begin
			d = DUTY_W'(clip_one((64'(ay) << DUTY_FRAC_BITS) / amp_eff()));
			o.drive_mode = MODE_NS;
			o.motor_a_duty = d; o.motor_a_forward = !sy ? 1'b0 : 1'b1;
			o.motor_b_duty = d; o.motor_b_forward = !sy ? 1'b0 : 1'b1;
			o.motor_c_duty = d; o.motor_c_forward = !sy;
			o.motor_d_duty = d; o.motor_d_forward = !sy;
		end else if (ax > 2 * ay) begin
			d = DUTY_W'(clip_one((64'(ax) << DUTY_FRAC_BITS) / amp_eff()));
			o.drive_mode = MODE_EW;
			o.motor_a_duty = d; o.motor_a_forward = !sx;
			o.motor_b_duty = d; o.motor_b_forward = sx;
			o.motor_c_duty = d; o.motor_c_forward = sx;
			o.motor_d_duty = d; o.motor_d_forward = !sx;
		end else if (diag && sx != sy) begin
			d = DUTY_W'(diag_rate(ax, ay));
			o.drive_mode = MODE_NWSE;
			o.motor_a_duty = d; o.motor_a_forward = !sx;
			o.motor_c_duty = d; o.motor_c_forward = sx;
		end else if (diag) begin
			d = DUTY_W'(diag_rate(ax, ay));
			o.drive_mode = MODE_NESW;
			o.motor_b_duty = d; o.motor_b_forward = sx;
			o.motor_d_duty = d; o.motor_d_forward = !sx;
		end else if (r != 0) begin
			d = DUTY_W'(clip_one((64'(ar) << DUTY_FRAC_BITS) / amp_eff()));
			o.drive_mode = sr ? MODE_CCW : MODE_CW;
			o.motor_a_duty = d; o.motor_a_forward = !sr;
			o.motor_b_duty = d; o.motor_b_forward = !sr;
			o.motor_c_duty = d; o.motor_c_forward = !sr;
			o.motor_d_duty = d; o.motor_d_forward = !sr;
		end else begin
			o = '0;
			o.drive_mode = MODE_STOP;
		end
		return o;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %0t: %s got %0d want %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_t w;
		if (!arst_n) begin
			mid_q <= MID_POINT_RST;
			band_q <= DEADBAND_RST;
			tol_q <= DIAG_TOL_RST;
			amp_q <= AMPLITUDE_RST;
			drive_q.delete();
			fail_count = 0;
		end else begin
			// compare before the register update and before queueing this edge's beat
			if (out_valid && out_ready) begin
				if (drive_q.size() == 0) begin
					report_mismatch("unexpected beat", 0, 0);
				end else begin
					w = drive_q.pop_front();
					if (out_data.drive_mode != w.drive_mode)
						report_mismatch("drive_mode", out_data.drive_mode, w.drive_mode);
					if (out_data.motor_a_duty != w.motor_a_duty)
						report_mismatch("motor_a_duty", out_data.motor_a_duty, w.motor_a_duty);
					if (out_data.motor_a_forward != w.motor_a_forward)
						report_mismatch("motor_a_fwd", out_data.motor_a_forward, w.motor_a_forward);
					if (out_data.motor_b_duty != w.motor_b_duty)
						report_mismatch("motor_b_duty", out_data.motor_b_duty, w.motor_b_duty);
					if (out_data.motor_b_forward != w.motor_b_forward)
						report_mismatch("motor_b_fwd", out_data.motor_b_forward, w.motor_b_forward);
					if (out_data.motor_c_duty != w.motor_c_duty)
						report_mismatch("motor_c_duty", out_data.motor_c_duty, w.motor_c_duty);
					if (out_data.motor_c_forward != w.motor_c_forward)
						report_mismatch("motor_c_fwd", out_data.motor_c_forward, w.motor_c_forward);
					if (out_data.motor_d_duty != w.motor_d_duty)
						report_mismatch("motor_d_duty", out_data.motor_d_duty, w.motor_d_duty);
					if (out_data.motor_d_forward != w.motor_d_forward)
						report_mismatch("motor_d_fwd", out_data.motor_d_forward, w.motor_d_forward);
				end
			end
			if (in_valid && in_ready)
				drive_q.push_back(mix_sticks(in_data));
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_MID_POINT: mid_q <= cfg_data;
					CFG_DEADBAND:  band_q <= cfg_data[DB_W-1:0];
					CFG_DIAG_TOL:  tol_q <= cfg_data[DB_W-1:0];
					CFG_AMPLITUDE: amp_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

endmodule

// ----- tb/sv/omni_drive_joystick_mixer_tb.sv -----
// Top of the mixer testbench: clock, reset, stimulus, register phases and verdict.
`timescale 1ns / 1ps
module omni_drive_joystick_mixer_tb;
	import ojm_pkg::*;

	localparam int LATENCY = 2 * DUTY_FRAC_BITS_DEF + 24;
	localparam int STALL_LIMIT = 2000;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	in_t                   in_data;
	logic                  out_valid;
	logic                  out_ready;
	out_t                  out_data;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    fail_count;
	int                    pending_count;
	int                    quiet_cycles = 0;
	bit                    calm;
	bit                    sink_stop;

	omni_drive_joystick_mixer dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	omni_drive_joystick_mixer_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending_count(pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// receiver: random hold-off bursts until the calm tail of the run
	initial begin
		out_ready = 1'b0;
		sink_stop = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!calm && !sink_stop && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 30)) @(posedge clk);
			end
		end
	end

	// watchdog on cycles with no beat on any channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic send_reading(logic [9:0] lx, logic [9:0] ly, logic [9:0] rx);
		if (!calm && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{left_x_permille: lx, left_y_permille: ly, right_x_permille: rx};
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic drain_pipe();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, int value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(value);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic load_regs(int mid, int band, int tol, int amp);
		write_reg(CFG_MID_POINT, mid);
		write_reg(CFG_DEADBAND, band);
		write_reg(CFG_DIAG_TOL, tol);
		write_reg(CFG_AMPLITUDE, amp);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// mostly near the centre so every mode turns up; some full-range noise
	function automatic logic [9:0] pick_reading(int mid, int spread);
		int v;
		if ($urandom_range(0, 9) == 0)
			return 10'($urandom);
		v = mid + $urandom_range(0, 2 * spread) - spread;
		if ($urandom_range(0, 4) == 0)
			v = mid;
		if (v < 0) v = 0;
		if (v > 1023) v = 1023;
		return 10'(v);
	endfunction

	task automatic random_phase(int count, int mid, int spread);
		int dx;
		logic [9:0] lx;
		for (int i = 0; i < count; i++) begin
			lx = pick_reading(mid, spread);
			if ($urandom_range(0, 3) == 0) begin
				// steer towards a diagonal
				dx = int'(lx) - mid;
				dx = ($urandom_range(0, 1) ? dx : -dx) + $urandom_range(0, 6) - 3;
				send_reading(lx, 10'((mid + dx) < 0 ? 0 : ((mid + dx) > 1023 ? 1023 : mid + dx)),
					pick_reading(mid, spread));
			end else begin
				send_reading(lx, pick_reading(mid, spread), pick_reading(mid, spread));
			end
		end
	endtask

	initial begin
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		calm = 1'b0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed beats at reset settings: each mode, extremes, deadband edges
		send_reading(10'd83, 10'd83, 10'd83);
		send_reading(10'd83, 10'd200, 10'd83);
		send_reading(10'd83, 10'd0, 10'd83);
		send_reading(10'd200, 10'd83, 10'd83);
		send_reading(10'd0, 10'd83, 10'd83);
		send_reading(10'd100, 10'd66, 10'd83);
		send_reading(10'd66, 10'd100, 10'd83);
		send_reading(10'd100, 10'd100, 10'd83);
		send_reading(10'd66, 10'd66, 10'd83);
		send_reading(10'd83, 10'd83, 10'd0);
		send_reading(10'd83, 10'd83, 10'd1023);
		send_reading(10'd85, 10'd83, 10'd86);
		send_reading(10'd1023, 10'd1023, 10'd1023);
		send_reading(10'd0, 10'd0, 10'd0);
		send_reading(10'd1023, 10'd0, 10'd512);
		send_reading(10'd90, 10'd88, 10'd84);
		send_reading(10'd83, 10'd83, 10'd82);
		// hold off until every expected result is back
		drain_pipe();

		random_phase(300, 83, 60);
		drain_pipe();

		load_regs(0, 0, 0, 0);
		send_reading(10'd0, 10'd0, 10'd1);
		send_reading(10'd1, 10'd1, 10'd0);
		random_phase(250, 0, 40);
		drain_pipe();

		load_regs(1000, 255, 255, 1000);
		send_reading(10'd1023, 10'd1000, 10'd1000);
		random_phase(300, 700, 300);
		drain_pipe();

		load_regs(512, 8, 40, 1);
		random_phase(300, 512, 30);
		drain_pipe();

		load_regs(500, 2, 20, 500);
		random_phase(350, 500, 500);
		drain_pipe();

		calm = 1'b1;
		load_regs(300, 5, 15, 97);
		random_phase(350, 300, 200);
		drain_pipe();
		repeat (LATENCY) @(posedge clk);

		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
